// ----- src/rau_pkg.sv -----
// rau_pkg: shared constants, opcode and status codes, back-end state type
// and queue status struct for the rational arithmetic unit.
// No dependencies.
package rau_pkg;

   localparam int DATA_WIDTH      = 32;
   localparam int DEN_WIDTH       = 31;
   localparam int CMD_WIDTH       = 4;
   localparam int STATUS_WIDTH    = 2;
   localparam int VALUE_WIDTH_DEF = 32;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic [CMD_WIDTH-1:0] CMD_REDUCE = 4'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_ADD    = 4'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_SUB    = 4'd2;
   localparam logic [CMD_WIDTH-1:0] CMD_MUL    = 4'd3;
   localparam logic [CMD_WIDTH-1:0] CMD_DIV    = 4'd4;
   localparam logic [CMD_WIDTH-1:0] CMD_INC    = 4'd5;
   localparam logic [CMD_WIDTH-1:0] CMD_DEC    = 4'd6;
   localparam logic [CMD_WIDTH-1:0] CMD_EQ     = 4'd7;
   localparam logic [CMD_WIDTH-1:0] CMD_NE     = 4'd8;
   localparam logic [CMD_WIDTH-1:0] CMD_GT     = 4'd9;
   localparam logic [CMD_WIDTH-1:0] CMD_GE     = 4'd10;
   localparam logic [CMD_WIDTH-1:0] CMD_LE     = 4'd11;
   localparam logic [CMD_WIDTH-1:0] CMD_WHOLE  = 4'd12;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK       = 2'd0,
      ST_DIV_ZERO = 2'd1,
      ST_OVERFLOW = 2'd2,
      ST_BAD_OP   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_MUL1,
      BK_MUL2,
      BK_MUL3,
      BK_ADD,
      BK_GCD,
      BK_DIV_NUM,
      BK_DIV_DEN,
      BK_CHECK,
      BK_WHOLE,
      BK_DONE
   } back_state_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage

// ----- src/rau_front.sv -----
// rau_front: accepts a command, splits the operands into sign and magnitude,
// checks for zero divisors and bad opcodes and picks the factors of three product terms.
// Depends on rau_pkg.
module rau_front
   #(parameter int VALUE_WIDTH = rau_pkg::VALUE_WIDTH_DEF,
     localparam int ItemWidth = rau_pkg::CMD_WIDTH + rau_pkg::STATUS_WIDTH + 3
                                + 6 * VALUE_WIDTH)
   (input  logic                                     start,
    output logic                                     busy,
    input  logic [rau_pkg::CMD_WIDTH-1:0]            req_cmd,
    input  logic signed [rau_pkg::DATA_WIDTH-1:0]    req_a_num,
    input  logic signed [rau_pkg::DATA_WIDTH-1:0]    req_a_den,
    input  logic signed [rau_pkg::DATA_WIDTH-1:0]    req_b_num,
    input  logic signed [rau_pkg::DATA_WIDTH-1:0]    req_b_den,
    input  rau_pkg::queue_stat_type                  q_stat,
    output logic                                     push,
    output logic [ItemWidth-1:0]                     item);

   import rau_pkg::*;

   localparam int W = VALUE_WIDTH;

   // {sign, magnitude} of the low W bits taken as two's complement
   function automatic logic [W:0] take(input logic [DATA_WIDTH-1:0] raw);
      logic [W-1:0] v;
      logic         neg;
      v   = raw[W-1:0];
      neg = v[W-1];
      return {neg, neg ? (~v + W'(1)) : v};
   endfunction

   logic [W:0]   an, ad, bn, bd;
   logic         an_s, ad_s, bn_s, bd_s;
   logic [W-1:0] an_m, ad_m, bn_m, bd_m;
   logic         ad_z, bd_z, bn_z;
   logic [W-1:0] one;
   logic [W-1:0] x1, y1, x2, y2, x3, y3;
   logic         s1, s2, s3;
   status_type   st;

   assign an = take(req_a_num);
   assign ad = take(req_a_den);
   assign bn = take(req_b_num);
   assign bd = take(req_b_den);
   assign {an_s, an_m} = an;
   assign {ad_s, ad_m} = ad;
   assign {bn_s, bn_m} = bn;
   assign {bd_s, bd_m} = bd;
   assign ad_z = (ad_m == '0);
   assign bd_z = (bd_m == '0);
   assign bn_z = (bn_m == '0);
   assign one  = W'(1);

   // numerator = x1*y1 + x2*y2, denominator = x3*y3, signs per term
   always_comb begin
      x1 = '0; y1 = '0; s1 = 1'b0;
      x2 = '0; y2 = '0; s2 = 1'b0;
      x3 = '0; y3 = '0; s3 = 1'b0;
      st = ST_OK;
      unique case (req_cmd)
         CMD_REDUCE, CMD_WHOLE: begin
            x1 = an_m; y1 = one; s1 = an_s;
            x3 = ad_m; y3 = one; s3 = ad_s;
            if (ad_z) st = ST_DIV_ZERO;
         end
         CMD_ADD, CMD_SUB: begin
            x1 = an_m; y1 = bd_m; s1 = an_s ^ bd_s;
            x2 = bn_m; y2 = ad_m; s2 = bn_s ^ ad_s ^ (req_cmd == CMD_SUB);
            x3 = ad_m; y3 = bd_m; s3 = ad_s ^ bd_s;
            if (ad_z || bd_z) st = ST_DIV_ZERO;
         end
         CMD_MUL: begin
            x1 = an_m; y1 = bn_m; s1 = an_s ^ bn_s;
            x3 = ad_m; y3 = bd_m; s3 = ad_s ^ bd_s;
            if (ad_z || bd_z) st = ST_DIV_ZERO;
         end
         CMD_DIV: begin
            x1 = an_m; y1 = bd_m; s1 = an_s ^ bd_s;
            x3 = ad_m; y3 = bn_m; s3 = ad_s ^ bn_s;
            if (ad_z || bd_z || bn_z) st = ST_DIV_ZERO;
         end
         CMD_INC, CMD_DEC: begin
            x1 = an_m; y1 = one; s1 = an_s;
            x2 = ad_m; y2 = one; s2 = ad_s ^ (req_cmd == CMD_DEC);
            x3 = ad_m; y3 = one; s3 = ad_s;
            if (ad_z) st = ST_DIV_ZERO;
         end
         CMD_EQ, CMD_NE, CMD_GT, CMD_GE, CMD_LE: begin
            // a/ad - b/bd, sign taken from cross products
            x1 = an_m; y1 = bd_m; s1 = an_s ^ ad_s;
            x2 = bn_m; y2 = ad_m; s2 = ~(bn_s ^ bd_s);
            if (ad_z || bd_z) st = ST_DIV_ZERO;
         end
         default: st = ST_BAD_OP;
      endcase
   end

   assign busy = q_stat.full;
   assign push = start & ~busy;
   assign item = {req_cmd, st, s1, s2, s3, x1, y1, x2, y2, x3, y3};

endmodule

// ----- src/rau_fifo.sv -----
// rau_fifo: short register queue between the front and back ends.
// Depends on rau_pkg.
module rau_fifo
   #(parameter int WIDTH = rau_pkg::DATA_WIDTH,
     parameter int DEPTH = rau_pkg::QUEUE_DEPTH_DEF)
   (input  logic                     clock,
    input  logic                     reset,
    input  logic                     push,
    input  logic                     pop,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata,
    output rau_pkg::queue_stat_type  stat);

   import rau_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;

   assign wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
   assign rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + CW'(1);
      else if (pop && !push) cnt_in = cnt_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_in;
         if (pop) rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= wdata;
   end

   assign rdata      = slot_ff[rd_ff];
   assign stat.full  = (cnt_ff == CW'(DEPTH));
   assign stat.empty = (cnt_ff == '0);

endmodule

// ----- src/rau_div.sv -----
// rau_div: bit-serial restoring divider, one quotient bit per cycle.
// Depends on rau_pkg.
module rau_div
   #(parameter int WIDTH = rau_pkg::DATA_WIDTH)
   (input  logic             clock,
    input  logic             reset,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder);

   import rau_pkg::*;

   localparam int CW = $clog2(WIDTH + 1);

   logic             busy_ff, done_ff;
   logic [CW-1:0]    cnt_ff;
   logic [WIDTH-1:0] q_ff, q_in, d_ff, rem_ff, rem_in;
   logic [WIDTH:0]   rem_sh;
   logic             ge;

   assign rem_sh = {rem_ff, q_ff[WIDTH-1]};
   assign ge     = (rem_sh >= {1'b0, d_ff});
   assign rem_in = ge ? WIDTH'(rem_sh - {1'b0, d_ff}) : rem_sh[WIDTH-1:0];
   assign q_in   = {q_ff[WIDTH-2:0], ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CW'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= dividend;
         d_ff   <= divisor;
         rem_ff <= '0;
         cnt_ff <= CW'(WIDTH);
      end else if (busy_ff) begin
         q_ff   <= q_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff - CW'(1);
      end
   end

   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = rem_ff;

endmodule

// ----- src/rau_back.sv -----
// rau_back: sequencer that forms the products, the signed sum, the binary gcd,
// the reducing divides and the whole-part split, then drives one result.
// Depends on rau_pkg and rau_div.
module rau_back
   #(parameter int VALUE_WIDTH = rau_pkg::VALUE_WIDTH_DEF,
     localparam int ItemWidth = rau_pkg::CMD_WIDTH + rau_pkg::STATUS_WIDTH + 3
                                + 6 * VALUE_WIDTH)
   (input  logic                                  clock,
    input  logic                                  reset,
    input  rau_pkg::queue_stat_type               q_stat,
    input  logic [ItemWidth-1:0]                  item,
    output logic                                  pop,
    output logic                                  rsp_valid,
    output logic signed [rau_pkg::DATA_WIDTH-1:0] rsp_res_num,
    output logic [rau_pkg::DEN_WIDTH-1:0]         rsp_res_den,
    output logic [rau_pkg::DEN_WIDTH-1:0]         rsp_whole_part,
    output logic                                  rsp_compare_true,
    output logic [rau_pkg::STATUS_WIDTH-1:0]      rsp_status);

   import rau_pkg::*;

   localparam int W     = VALUE_WIDTH;
   localparam int PW    = 2 * W;
   localparam int M     = 2 * W + 1;
   localparam int KW    = $clog2(M + 1);
   localparam int StOfs = 3 + 6 * W;

   back_state_type state_ff, state_in;

   logic [ItemWidth-1:0]  item_ff;
   logic [CMD_WIDTH-1:0]  cmd;
   logic                  s1, s2, s3;
   logic [W-1:0]          x1, y1, x2, y2, x3, y3;
   status_type            q_st;

   logic [PW-1:0]  p1_ff, p2_ff, d_mag_ff, prod;
   logic [W-1:0]   mul_x, mul_y;
   logic [M-1:0]   n_mag_ff, sum_mag, p1_x, p2_x;
   logic           n_neg_ff, sum_neg;
   logic [M-1:0]   gu_ff, gv_ff, g_ff, gu_in, gv_in;
   logic [KW-1:0]  gk_ff, gk_in;
   logic           gcd_done;
   logic [M-1:0]   a_ff, b_ff, whole_ff, lim;
   logic           sgn_ff, sgn_c, ovf;
   status_type     st_ff;
   logic           is_cmp, cmp_v;
   logic [W-1:0]   a_w, num_w;

   logic           div_go_ff, div_done;
   logic [M-1:0]   div_dividend, div_divisor, div_q, div_r;

   logic                           rsp_valid_ff;
   logic signed [DATA_WIDTH-1:0]   rsp_num_ff;
   logic [DEN_WIDTH-1:0]           rsp_den_ff, rsp_whole_ff;
   logic                           rsp_cmp_ff;
   status_type                     rsp_st_ff;

   assign cmd = item_ff[ItemWidth-1 -: CMD_WIDTH];
   assign {s1, s2, s3, x1, y1, x2, y2, x3, y3} = item_ff[StOfs-1:0];
   assign q_st   = status_type'(item[StOfs +: STATUS_WIDTH]);
   assign is_cmp = (cmd >= CMD_EQ) && (cmd <= CMD_LE);

   // product terms
   assign prod = PW'(mul_x) * PW'(mul_y);
   assign p1_x = M'(p1_ff);
   assign p2_x = M'(p2_ff);

   // signed magnitude add, zero always positive
   always_comb begin
      if (s1 == s2) begin
         sum_mag = p1_x + p2_x;
         sum_neg = s1;
      end else if (p1_x >= p2_x) begin
         sum_mag = p1_x - p2_x;
         sum_neg = s1;
      end else begin
         sum_mag = p2_x - p1_x;
         sum_neg = s2;
      end
      if (sum_mag == '0) sum_neg = 1'b0;
   end

   // one binary gcd step
   assign gcd_done = (gu_ff == '0) || (gv_ff == '0);
   always_comb begin
      gu_in = gu_ff;
      gv_in = gv_ff;
      gk_in = gk_ff;
      priority if (!gu_ff[0] && !gv_ff[0]) begin
         gu_in = gu_ff >> 1;
         gv_in = gv_ff >> 1;
         gk_in = gk_ff + KW'(1);
      end else if (!gu_ff[0]) begin
         gu_in = gu_ff >> 1;
      end else if (!gv_ff[0]) begin
         gv_in = gv_ff >> 1;
      end else if (gu_ff >= gv_ff) begin
         gu_in = gu_ff - gv_ff;
      end else begin
         gv_in = gv_ff - gu_ff;
      end
   end

   // range check of the reduced fraction
   assign lim   = M'(1) << (W - 1);
   assign sgn_c = (n_neg_ff ^ s3) && (a_ff != '0);
   assign ovf   = (b_ff >= lim) || (sgn_c ? (a_ff > lim) : (a_ff >= lim));

   always_comb begin
      unique case (cmd)
         CMD_EQ:  cmp_v = (n_mag_ff == '0);
         CMD_NE:  cmp_v = (n_mag_ff != '0);
         CMD_GT:  cmp_v = !n_neg_ff && (n_mag_ff != '0);
         CMD_GE:  cmp_v = !n_neg_ff;
         CMD_LE:  cmp_v = n_neg_ff || (n_mag_ff == '0);
         default: cmp_v = 1'b0;
      endcase
   end

   assign a_w   = a_ff[W-1:0];
   assign num_w = sgn_ff ? (~a_w + W'(1)) : a_w;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:    if (!q_stat.empty) state_in = (q_st != ST_OK) ? BK_DONE : BK_MUL1;
         BK_MUL1:    state_in = BK_MUL2;
         BK_MUL2:    state_in = BK_MUL3;
         BK_MUL3:    state_in = BK_ADD;
         BK_ADD:     state_in = is_cmp ? BK_DONE : BK_GCD;
         BK_GCD:     if (gcd_done) state_in = BK_DIV_NUM;
         BK_DIV_NUM: if (div_done) state_in = BK_DIV_DEN;
         BK_DIV_DEN: if (div_done) state_in = BK_CHECK;
         BK_CHECK: begin
            if (ovf) state_in = BK_DONE;
            else if (cmd == CMD_WHOLE && !sgn_c) state_in = BK_WHOLE;
            else state_in = BK_DONE;
         end
         BK_WHOLE:   if (div_done) state_in = BK_DONE;
         BK_DONE:    state_in = BK_IDLE;
         default:    state_in = BK_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      pop          = 1'b0;
      mul_x        = x1;
      mul_y        = y1;
      div_dividend = n_mag_ff;
      div_divisor  = g_ff;
      unique case (state_ff)
         BK_IDLE:    pop = !q_stat.empty;
         BK_MUL2: begin
            mul_x = x2;
            mul_y = y2;
         end
         BK_MUL3: begin
            mul_x = x3;
            mul_y = y3;
         end
         BK_DIV_DEN: div_dividend = M'(d_mag_ff);
         BK_WHOLE: begin
            div_dividend = a_ff;
            div_divisor  = b_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         div_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_go_ff    <= (state_in != state_ff) &&
                         (state_in == BK_DIV_NUM || state_in == BK_DIV_DEN ||
                          state_in == BK_WHOLE);
         rsp_valid_ff <= (state_ff == BK_DONE);
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         BK_IDLE: begin
            if (pop) begin
               item_ff  <= item;
               st_ff    <= q_st;
               whole_ff <= '0;
               sgn_ff   <= 1'b0;
            end
         end
         BK_MUL1: p1_ff    <= prod;
         BK_MUL2: p2_ff    <= prod;
         BK_MUL3: d_mag_ff <= prod;
         BK_ADD: begin
            n_mag_ff <= sum_mag;
            n_neg_ff <= sum_neg;
            gu_ff    <= sum_mag;
            gv_ff    <= M'(d_mag_ff);
            gk_ff    <= '0;
         end
         BK_GCD: begin
            if (gcd_done) g_ff <= (gu_ff | gv_ff) << gk_ff;
            else begin
               gu_ff <= gu_in;
               gv_ff <= gv_in;
               gk_ff <= gk_in;
            end
         end
         BK_DIV_NUM: if (div_done) a_ff <= div_q;
         BK_DIV_DEN: if (div_done) b_ff <= div_q;
         BK_CHECK: begin
            sgn_ff <= sgn_c;
            if (ovf) st_ff <= ST_OVERFLOW;
         end
         BK_WHOLE: begin
            if (div_done) begin
               whole_ff <= div_q;
               a_ff     <= div_r;
            end
         end
         BK_DONE: begin
            rsp_st_ff    <= st_ff;
            rsp_num_ff   <= '0;
            rsp_den_ff   <= '0;
            rsp_whole_ff <= '0;
            rsp_cmp_ff   <= 1'b0;
            if (st_ff == ST_OK) begin
               if (is_cmp) rsp_cmp_ff <= cmp_v;
               else begin
                  rsp_num_ff   <= DATA_WIDTH'(signed'(num_w));
                  rsp_den_ff   <= DEN_WIDTH'(b_ff[W-2:0]);
                  rsp_whole_ff <= DEN_WIDTH'(whole_ff[W-2:0]);
               end
            end
         end
         default: ;
      endcase
   end

   rau_div #(.WIDTH(M)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_go_ff),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r));

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_res_num      = rsp_num_ff;
   assign rsp_res_den      = rsp_den_ff;
   assign rsp_whole_part   = rsp_whole_ff;
   assign rsp_compare_true = rsp_cmp_ff;
   assign rsp_status       = rsp_st_ff;

endmodule

// ----- src/rational_arithmetic_unit_core.sv -----
// rational_arithmetic_unit_core: rational arithmetic unit top level.
// Depends on rau_pkg, rau_front, rau_fifo, rau_back.
//
// Usage: drive req_cmd and the four operand fields and raise start; the
// command is taken at a clock edge with start high and busy low. busy is
// high only while the command queue (QUEUE_DEPTH entries) is full, so the
// front end keeps accepting while the back end works on an earlier command.
// Each command gives one result on the rsp_ ports, valid for exactly one
// cycle while rsp_valid is high; the receiver cannot hold it off.
// A rejected command (zero divisor, bad opcode) goes straight from idle to
// the result; a compare passes the three multiply steps and the signed add;
// a fraction result adds the binary gcd loop and two or three passes of the
// bit-serial divider (numerator, denominator, and the whole part for a
// non-negative CMD_WHOLE). The gcd loop and the single shared divider set
// the throughput, one command at a time in the back end.
// Reset empties the queue and returns the sequencer to idle; no result is
// issued for a command lost to reset.
module rational_arithmetic_unit_core
   #(parameter int VALUE_WIDTH = rau_pkg::VALUE_WIDTH_DEF,
     parameter int QUEUE_DEPTH = rau_pkg::QUEUE_DEPTH_DEF)
   (input  logic                                  clock,
    input  logic                                  reset,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [rau_pkg::CMD_WIDTH-1:0]         req_cmd,
    input  logic signed [rau_pkg::DATA_WIDTH-1:0] req_a_num,
    input  logic signed [rau_pkg::DATA_WIDTH-1:0] req_a_den,
    input  logic signed [rau_pkg::DATA_WIDTH-1:0] req_b_num,
    input  logic signed [rau_pkg::DATA_WIDTH-1:0] req_b_den,
    output logic                                  rsp_valid,
    output logic signed [rau_pkg::DATA_WIDTH-1:0] rsp_res_num,
    output logic [rau_pkg::DEN_WIDTH-1:0]         rsp_res_den,
    output logic [rau_pkg::DEN_WIDTH-1:0]         rsp_whole_part,
    output logic                                  rsp_compare_true,
    output logic [rau_pkg::STATUS_WIDTH-1:0]      rsp_status);

   import rau_pkg::*;

   localparam int ItemWidth = CMD_WIDTH + STATUS_WIDTH + 3 + 6 * VALUE_WIDTH;

   queue_stat_type       q_stat;
   logic                 push, pop;
   logic [ItemWidth-1:0] f_item, b_item;

   rau_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
      .start     (start),
      .busy      (busy),
      .req_cmd   (req_cmd),
      .req_a_num (req_a_num),
      .req_a_den (req_a_den),
      .req_b_num (req_b_num),
      .req_b_den (req_b_den),
      .q_stat    (q_stat),
      .push      (push),
      .item      (f_item));

   rau_fifo #(.WIDTH(ItemWidth), .DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .wdata (f_item),
      .rdata (b_item),
      .stat  (q_stat));

   rau_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_stat           (q_stat),
      .item             (b_item),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_res_num      (rsp_res_num),
      .rsp_res_den      (rsp_res_den),
      .rsp_whole_part   (rsp_whole_part),
      .rsp_compare_true (rsp_compare_true),
      .rsp_status       (rsp_status));

endmodule

// ----- src/rau_checker.sv -----
// rau_checker: port-level assertions for the rational arithmetic unit,
// bound to rational_arithmetic_unit_core. Depends on rau_pkg.
module rau_checker
   (input logic                                  clock,
    input logic                                  reset,
    input logic                                  start,
    input logic                                  busy,
    input logic                                  rsp_valid,
    input logic signed [rau_pkg::DATA_WIDTH-1:0] rsp_res_num,
    input logic [rau_pkg::DEN_WIDTH-1:0]         rsp_res_den,
    input logic [rau_pkg::DEN_WIDTH-1:0]         rsp_whole_part,
    input logic                                  rsp_compare_true,
    input logic [rau_pkg::STATUS_WIDTH-1:0]      rsp_status);

   import rau_pkg::*;

   // the sequencer returns to idle between results
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   a_reset_clears: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !busy && !rsp_valid)
      else $error("busy or result strobe set right after reset");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |->
         rsp_res_num == 0 && rsp_res_den == 0 && rsp_whole_part == 0 &&
         !rsp_compare_true)
      else $error("error result carries data");

   a_compare_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_compare_true |->
         rsp_res_num == 0 && rsp_res_den == 0 && rsp_status == ST_OK)
      else $error("compare result carries fraction data");

   a_ok_fraction_den: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OK && rsp_res_num != 0 |-> rsp_res_den != 0)
      else $error("fraction result with zero denominator");

endmodule

bind rational_arithmetic_unit_core rau_checker u_rau_checker (.*);

// ----- tb/rational_arithmetic_unit_core_tb.sv -----
// rational_arithmetic_unit_core_tb: self-checking bench for the rational unit.
// Depends on rau_pkg and rational_arithmetic_unit_core; a fraction predictor
// in a small scoreboard class checks every result beat in order.
module rational_arithmetic_unit_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rau_pkg::*;

   localparam int VW = VALUE_WIDTH_DEF;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      logic signed [31:0] res_num;
      logic [30:0]        res_den;
      logic [30:0]        whole_part;
      logic               compare_true;
      status_type         status;
   } frac_result_type;

   typedef struct {
      bit          neg;
      bit [63:0]   mag;
   } smag_type;

   class frac_scoreboard;
      frac_result_type pending[$];
      int errors = 0;

      function smag_type fix(smag_type x);
         if (x.mag == 0) x.neg = 0;
         return x;
      endfunction

      function smag_type take(logic [31:0] raw);
         smag_type r;
         bit [63:0] span;
         bit [63:0] m;
         span = 64'd1 << VW;
         m = {32'd0, raw} & (span - 1);
         r.neg = m[VW-1];
         r.mag = r.neg ? span - m : m;
         return r;
      endfunction

      function smag_type mul(smag_type a, smag_type b);
         smag_type r;
         r.neg = a.neg != b.neg;
         r.mag = a.mag * b.mag;
         return fix(r);
      endfunction

      function smag_type negate(smag_type a);
         a.neg = !a.neg;
         return fix(a);
      endfunction

      function smag_type add(smag_type a, smag_type b);
         smag_type r;
         if (a.neg == b.neg) begin
            r.neg = a.neg; r.mag = a.mag + b.mag;
         end else if (a.mag >= b.mag) begin
            r.neg = a.neg; r.mag = a.mag - b.mag;
         end else begin
            r.neg = b.neg; r.mag = b.mag - a.mag;
         end
         return fix(r);
      endfunction

      function int compare(smag_type x, smag_type y);
         x = fix(x); y = fix(y);
         if (x.neg != y.neg) return x.neg ? -1 : 1;
         if (x.mag == y.mag) return 0;
         if (x.mag < y.mag) return x.neg ? 1 : -1;
         return x.neg ? -1 : 1;
      endfunction

      function bit [63:0] gcd(bit [63:0] a, bit [63:0] b);
         bit [63:0] t;
         while (b != 0) begin
            t = a % b; a = b; b = t;
         end
         return a;
      endfunction

      function frac_result_type compute(logic [3:0] cmd, logic [31:0] an_raw,
                                        logic [31:0] ad_raw, logic [31:0] bn_raw,
                                        logic [31:0] bd_raw);
         frac_result_type r;
         smag_type an, ad, bn, bd, n, d, x, y, t;
         bit is_frac, neg, cmpv;
         bit [63:0] g, nm, dm, whole, lim;
         status_type st;
         int c;
         an = take(an_raw); ad = take(ad_raw);
         bn = take(bn_raw); bd = take(bd_raw);
         n = '{0, 0}; d = '{0, 0};
         is_frac = 1; cmpv = 0; neg = 0; nm = 0; dm = 0; whole = 0;
         st = ST_OK;
         lim = 64'd1 << (VW - 1);
         case (cmd)
            CMD_REDUCE, CMD_WHOLE: begin
               n = an; d = ad;
            end
            CMD_ADD, CMD_SUB, CMD_MUL: begin
               if (ad.mag == 0 || bd.mag == 0) st = ST_DIV_ZERO;
               else begin
                  if (cmd == CMD_MUL) n = mul(an, bn);
                  else begin
                     t = mul(bn, ad);
                     if (cmd == CMD_SUB) t = negate(t);
                     n = add(mul(an, bd), t);
                  end
                  d = mul(ad, bd);
               end
            end
            CMD_DIV: begin
               if (ad.mag == 0 || bd.mag == 0 || bn.mag == 0) st = ST_DIV_ZERO;
               else begin
                  n = mul(an, bd); d = mul(ad, bn);
               end
            end
            CMD_INC, CMD_DEC: begin
               if (ad.mag == 0) st = ST_DIV_ZERO;
               else begin
                  n = add(an, cmd == CMD_INC ? ad : negate(ad));
                  d = ad;
               end
            end
            CMD_EQ, CMD_NE, CMD_GT, CMD_GE, CMD_LE: begin
               is_frac = 0;
               if (ad.mag == 0 || bd.mag == 0) st = ST_DIV_ZERO;
               else begin
                  an.neg = an.neg != ad.neg; an = fix(an); ad.neg = 0;
                  bn.neg = bn.neg != bd.neg; bn = fix(bn); bd.neg = 0;
                  x = mul(an, bd); y = mul(bn, ad);
                  c = compare(x, y);
                  case (cmd)
                     CMD_EQ: cmpv = c == 0;
                     CMD_NE: cmpv = c != 0;
                     CMD_GT: cmpv = c > 0;
                     CMD_GE: cmpv = c >= 0;
                     default: cmpv = c <= 0;
                  endcase
               end
            end
            default: begin
               st = ST_BAD_OP; is_frac = 0;
            end
         endcase
         if (st == ST_OK && is_frac) begin
            if (d.mag == 0) st = ST_DIV_ZERO;
            else begin
               g = gcd(n.mag, d.mag);
               nm = n.mag / g; dm = d.mag / g;
               neg = (n.neg != d.neg) && nm != 0;
               if (dm > lim - 1 || nm > (neg ? lim : lim - 1)) st = ST_OVERFLOW;
               else if (cmd == CMD_WHOLE && !neg) begin
                  whole = nm / dm; nm = nm % dm;
               end
            end
         end
         r = '{0, 0, 0, 0, st};
         if (st == ST_OK) begin
            if (is_frac) begin
               r.res_num = neg ? -nm[31:0] : nm[31:0];
               r.res_den = dm[30:0];
               r.whole_part = whole[30:0];
            end else r.compare_true = cmpv;
         end
         return r;
      endfunction

      function void note_command(logic [3:0] cmd, logic [31:0] an, logic [31:0] ad,
                                 logic [31:0] bn, logic [31:0] bd);
         pending.push_back(compute(cmd, an, ad, bn, bd));
      endfunction

      function void check_result(frac_result_type got);
         frac_result_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result beat: num %0d status %0d",
                                       got.res_num, got.status);
            return;
         end
         want = pending.pop_front();
         if (got.res_num !== want.res_num || got.res_den !== want.res_den ||
             got.whole_part !== want.whole_part ||
             got.compare_true !== want.compare_true || got.status !== want.status) begin
            errors++;
            if (errors <= 10)
               $display({"result: exp num %0d den %0d whole %0d cmp %0b st %0d,",
                         " got %0d %0d %0d %0b %0d"},
                        want.res_num, want.res_den, want.whole_part, want.compare_true,
                        want.status, got.res_num, got.res_den, got.whole_part,
                        got.compare_true, got.status);
         end
      endfunction
   endclass

   logic clock = 0, reset = 1, start = 0;
   logic busy;
   logic [3:0] req_cmd = 0;
   logic signed [31:0] req_a_num = 0, req_a_den = 0, req_b_num = 0, req_b_den = 0;
   logic rsp_valid, rsp_compare_true;
   logic signed [31:0] rsp_res_num;
   logic [30:0] rsp_res_den, rsp_whole_part;
   logic [1:0] rsp_status;

   frac_scoreboard fracs = new();
   int idle_cycles = 0;
   bit calm = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   rational_arithmetic_unit_core DUT (.*);

   always @(posedge clock) begin
      if (!reset && start && !busy)
         fracs.note_command(req_cmd, req_a_num, req_a_den, req_b_num, req_b_den);
      if (!reset && rsp_valid)
         fracs.check_result('{rsp_res_num, rsp_res_den, rsp_whole_part,
                              rsp_compare_true, status_type'(rsp_status)});
      if ((start && !busy) || rsp_valid || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("rational_arithmetic_unit_core: mismatch");
         $finish;
      end
   end

   // one beat: present fields, hold start until accepted
   task automatic send_command(logic [3:0] cmd, logic [31:0] an, logic [31:0] ad,
                               logic [31:0] bn, logic [31:0] bd);
      while (!calm && $urandom_range(99) < 21) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1; req_cmd <= cmd;
      req_a_num <= an; req_a_den <= ad; req_b_num <= bn; req_b_den <= bd;
      do @(posedge clock); while (busy);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(5))
         0: return $urandom;
         1: return $urandom_range(20);
         2: return -$urandom_range(20);
         3: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff} ^ $urandom_range(3);
         default: return $urandom_range(5000) - 2500;
      endcase
   endfunction

   function automatic logic [31:0] pick_den();
      logic [31:0] v;
      v = pick_value();
      if (v == 0 && $urandom_range(9) != 0) v = 1;
      return v;
   endfunction

   initial begin
      logic [31:0] mx, mn;
      int wait_cycles;
      mx = 32'h7fff_ffff; mn = 32'h8000_0000;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      for (int op = 0; op < 16; op++)
         send_command(4'(op), 3, -6, 5, 4);
      send_command(CMD_REDUCE, 7, 0, 1, 1);
      send_command(CMD_DIV, 1, 2, 0, 3);
      send_command(CMD_MUL, mx, 1, mx, 1);
      send_command(CMD_ADD, mn, 1, mn, 1);
      send_command(CMD_REDUCE, mn, -1, 0, 1);
      send_command(CMD_WHOLE, -7, 2, 0, 1);
      send_command(CMD_WHOLE, mx, 3, 0, 1);
      send_command(CMD_EQ, 2, 4, -1, -2);
      send_command(CMD_LE, mn, mx, mx, mn);
      for (int i = 0; i < 1300; i++) begin
         calm = (i >= 500 && i < 650);
         send_command(4'($urandom_range(15)), pick_value(), pick_den(),
                      pick_value(), pick_den());
      end
      start <= 0;
      wait_cycles = 0;
      while (fracs.pending.size() != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (500) @(posedge clock);
      if (fracs.errors == 0 && fracs.pending.size() == 0)
         $display("rational_arithmetic_unit_core: match");
      else
         $display("rational_arithmetic_unit_core: mismatch");
      $finish;
   end
endmodule

// ----- filelist.f -----
src/rau_pkg.sv
src/rau_front.sv
src/rau_fifo.sv
src/rau_div.sv
src/rau_back.sv
src/rational_arithmetic_unit_core.sv
src/rau_checker.sv
tb/rational_arithmetic_unit_core_tb.sv
